FILE: rtl/core/sedist_pkg.sv
// shared constants and types of the spectral euclidean distance core
`default_nettype none

package sedist_pkg;

   // storage sizes
   localparam int MAX_WIDTH = 1024;
   localparam int MAX_BANDS = 256;

   // memory address widths
   localparam int COL_AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int BAND_AW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

   // counter and field widths
   localparam int COL_CNT_W  = 10;
   localparam int BAND_CNT_W = 8;
   localparam int ROW_CNT_W  = 10;
   localparam int SAMPLE_IN_W = 16;
   localparam int REF_BAND_W  = 8;
   localparam int SAMPLE_W    = 15;
   localparam int SQ_W        = 2 * SAMPLE_W;
   localparam int SUM_W       = 39;
   localparam int DIST_W      = 19;
   localparam int ROOT_W      = (SUM_W + 1) / 2;

   // configuration registers
   localparam int WIDTH_REG_W  = 11;
   localparam int BANDS_REG_W  = 9;
   localparam int HEIGHT_REG_W = 11;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 11;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(100);
   localparam logic [BANDS_REG_W-1:0]  BANDS_RESET  = BANDS_REG_W'(198);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(100);

   // saturation limits of the registers
   localparam logic [WIDTH_REG_W-1:0]  WLIM_MAX =
      WIDTH_REG_W'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
   localparam logic [BANDS_REG_W-1:0]  BLIM_MAX =
      BANDS_REG_W'((MAX_BANDS < 256) ? MAX_BANDS : 256);
   localparam logic [HEIGHT_REG_W-1:0] HLIM_MAX = HEIGHT_REG_W'(1024);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_BAND_COUNT   = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   // handoff to the root unit
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] radicand;
   } root_req_type;

endpackage

`default_nettype wire

FILE: rtl/core/sedist_isqrt.sv
// bit-serial floor square root, one result bit per cycle
`default_nettype none

module sedist_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  sedist_pkg::root_req_type    root_req,
   output logic                        done,
   output logic [sedist_pkg::ROOT_W-1:0] root
);
   import sedist_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [RAD_W-1:0] rad_ff;
   logic [REM_W-1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic             take;

   // one restoring step: bring down two bits, try 4*root+1
   always_comb begin
      rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial  = {{(REM_W - ROOT_W){1'b0}}, root_ff, 2'b01};
      take   = (rem_sh >= trial);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (root_req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(ROOT_W - 1);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (root_req.start) begin
         rad_ff  <= RAD_W'(root_req.radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
         root_ff <= {root_ff[ROOT_W-2:0], take};
      end
   end

   // root is final after the edge at which done is high
   assign done = busy_ff && (cnt_ff == '0);
   assign root = root_ff;

endmodule

`default_nettype wire

FILE: rtl/core/spectral_euclidean_distance_core.sv
// top level of the spectral euclidean distance core
`default_nettype none

// Takes band-interleaved-by-line samples one beat at a time and keeps a
// per-column running sum of squared differences from a reference spectrum
// in a 1024 x 39 memory; the reference lives in a 256 x 15 memory loaded by
// func=0 beats. A sample is worked as memory read, square, then accumulate
// and write back; items are worked one at a time, so a read never overlaps
// a pending write. On a pixel's last band a bit-serial square root follows,
// and its result is then handed to the output register. The output
// register frees the core, so a new beat is taken while a result waits.
module spectral_euclidean_distance_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [sedist_pkg::REF_BAND_W-1:0]     req_ref_band,
   input  logic signed [sedist_pkg::SAMPLE_IN_W-1:0] req_sample_value,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sedist_pkg::DIST_W-1:0]         rsp_distance,
   output logic [sedist_pkg::COL_CNT_W-1:0]      rsp_pixel_column,
   output logic [sedist_pkg::ROW_CNT_W-1:0]      rsp_pixel_row,
   output logic                                  rsp_frame_end,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sedist_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sedist_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sedist_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ADD  = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // memories
   logic [SAMPLE_W-1:0] ref_mem [MAX_BANDS];
   logic [SUM_W-1:0]    sum_mem [MAX_WIDTH];
   logic [SAMPLE_W-1:0] ref_rd_ff;
   logic [SUM_W-1:0]    sum_rd_ff;

   // registers and counters
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [BANDS_REG_W-1:0]  bands_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [COL_CNT_W-1:0]    col_cnt_ff, col_cnt_in;
   logic [BAND_CNT_W-1:0]   band_cnt_ff, band_cnt_in;
   logic [ROW_CNT_W-1:0]    row_cnt_ff, row_cnt_in;

   // item held while it is worked
   logic [COL_CNT_W-1:0] col_ff;
   logic [ROW_CNT_W-1:0] row_ff;
   logic                 band_zero_ff;
   logic                 last_band_ff;
   logic                 frame_ff;
   logic [SAMPLE_W-1:0]  sample_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [SUM_W-1:0]     base_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic [COL_CNT_W-1:0] out_col_ff;
   logic [ROW_CNT_W-1:0] out_row_ff;
   logic                 out_frame_ff;

   logic [WIDTH_REG_W-1:0]  wlim;
   logic [BANDS_REG_W-1:0]  blim;
   logic [HEIGHT_REG_W-1:0] hlim;
   logic [COL_CNT_W-1:0]    col_cur;
   logic [BAND_CNT_W-1:0]   band_cur;
   logic [ROW_CNT_W-1:0]    row_cur;
   logic                    last_col, last_band, last_row;
   logic                    accept, accept_sample, accept_load;
   logic [SAMPLE_W-1:0]     sample_in;
   logic [SAMPLE_W-1:0]     diff;
   logic [SUM_W-1:0]        sum_in;
   logic                    out_load;
   root_req_type            root_req;
   logic                    root_done;
   logic [ROOT_W-1:0]       root;

   assign accept        = req_valid && !req_stall;
   assign accept_sample = accept && req_func;
   assign accept_load   = accept && !req_func;
   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;

   // negative samples clamp to zero
   assign sample_in = req_sample_value[SAMPLE_IN_W-1] ? '0 :
                      req_sample_value[SAMPLE_W-1:0];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         bands_ff  <= BANDS_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= WIDTH_REG_W'(csr_data);
            CSR_BAND_COUNT:   bands_ff  <= BANDS_REG_W'(csr_data);
            CSR_IMAGE_HEIGHT: height_ff <= HEIGHT_REG_W'(csr_data);
            default: ;
         endcase
      end
   end

   // limits in use: zero reads as one, large values saturate
   always_comb begin
      wlim = (width_ff == '0) ? WIDTH_REG_W'(1) :
             (width_ff > WLIM_MAX) ? WLIM_MAX : width_ff;
      blim = (bands_ff == '0) ? BANDS_REG_W'(1) :
             (bands_ff > BLIM_MAX) ? BLIM_MAX : bands_ff;
      hlim = (height_ff == '0) ? HEIGHT_REG_W'(1) :
             (height_ff > HLIM_MAX) ? HLIM_MAX : height_ff;
   end

   // position of this sample and the counters after it
   always_comb begin
      col_cur  = (WIDTH_REG_W'(col_cnt_ff) >= wlim) ? '0 : col_cnt_ff;
      band_cur = (BANDS_REG_W'(band_cnt_ff) >= blim) ? '0 : band_cnt_ff;
      row_cur  = (HEIGHT_REG_W'(row_cnt_ff) >= hlim) ? '0 : row_cnt_ff;

      last_col  = (WIDTH_REG_W'(col_cur) + WIDTH_REG_W'(1)) >= wlim;
      last_band = (BANDS_REG_W'(band_cur) + BANDS_REG_W'(1)) >= blim;
      last_row  = (HEIGHT_REG_W'(row_cur) + HEIGHT_REG_W'(1)) >= hlim;

      col_cnt_in  = col_cur + COL_CNT_W'(1);
      band_cnt_in = band_cur;
      row_cnt_in  = row_cur;
      if (last_col) begin
         col_cnt_in = '0;
         if (!last_band) begin
            band_cnt_in = band_cur + BAND_CNT_W'(1);
         end else begin
            band_cnt_in = '0;
            row_cnt_in  = last_row ? '0 : row_cur + ROW_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         band_cnt_ff <= '0;
         row_cnt_ff  <= '0;
      end else if (accept_sample) begin
         col_cnt_ff  <= col_cnt_in;
         band_cnt_ff <= band_cnt_in;
         row_cnt_ff  <= row_cnt_in;
      end
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (accept_sample) begin
         col_ff       <= col_cur;
         row_ff       <= row_cur;
         band_zero_ff <= (band_cur == '0);
         last_band_ff <= last_band;
         frame_ff     <= last_col && last_row;
         sample_ff    <= sample_in;
      end
   end

   // reference memory: load on func=0 beats, read on samples
   always_ff @(posedge clock) begin
      if (accept_load && (int'(req_ref_band) < MAX_BANDS)) begin
         ref_mem[BAND_AW'(req_ref_band)] <= sample_in;
      end
      if (accept_sample) begin
         ref_rd_ff <= ref_mem[BAND_AW'(band_cur)];
      end
   end

   // column sum memory: read at accept, written back in the add cycle
   always_ff @(posedge clock) begin
      if ((state_ff == ST_ADD)) begin
         sum_mem[COL_AW'(col_ff)] <= sum_in;
      end
      if (accept_sample) begin
         sum_rd_ff <= sum_mem[COL_AW'(col_cur)];
      end
   end

   // square the band difference; band 0 restarts the sum
   assign diff = (sample_ff >= ref_rd_ff) ? sample_ff - ref_rd_ff : ref_rd_ff - sample_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         sq_ff   <= SQ_W'(diff) * SQ_W'(diff);
         base_ff <= band_zero_ff ? '0 : sum_rd_ff;
      end
   end

   assign sum_in = base_ff + SUM_W'(sq_ff);

   // root unit starts on the last band
   always_comb begin
      root_req.start    = (state_ff == ST_ADD) && last_band_ff;
      root_req.radicand = sum_in;
   end

   sedist_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .root_req (root_req),
      .done     (root_done),
      .root     (root)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept_sample) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = last_band_ff ? ST_ROOT : ST_IDLE;
         ST_ROOT: if (root_done) state_in = ST_DONE;
         ST_DONE: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         dist_ff      <= DIST_W'(root);
         out_col_ff   <= col_ff;
         out_row_ff   <= row_ff;
         out_frame_ff <= frame_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance     = dist_ff;
   assign rsp_pixel_column = out_col_ff;
   assign rsp_pixel_row    = out_row_ff;
   assign rsp_frame_end    = out_frame_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sedist_checker.sv
// port-level checks of the spectral euclidean distance core and their bind
`default_nettype none

module sedist_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_func,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [sedist_pkg::DIST_W-1:0]         rsp_distance,
   input  logic [sedist_pkg::COL_CNT_W-1:0]      rsp_pixel_column,
   input  logic [sedist_pkg::ROW_CNT_W-1:0]      rsp_pixel_row,
   input  logic                                  rsp_frame_end
);
   import sedist_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance) &&
         $stable(rsp_pixel_column) && $stable(rsp_pixel_row) && $stable(rsp_frame_end))
      else $error("stalled result beat changed");

   // a sample beat occupies the core for the next cycle
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func |=> req_stall)
      else $error("core free right after a sample beat");

   // a reference load never blocks the next beat
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_func |=> !req_stall)
      else $error("reference load stalled the request channel");

   // a result only appears out of sample work in progress
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without sample work");

endmodule

bind spectral_euclidean_distance_core sedist_checker u_sedist_checker (.*);

`default_nettype wire

FILE: dv/spectral_euclidean_distance_core_tb.sv
// self-checking testbench for the spectral euclidean distance core
`default_nettype none

module spectral_euclidean_distance_core_tb;
   import sedist_pkg::*;

   // beat function codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // cycles the core may still be busy after its last result
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_CAP    = 100;
   // columns that a later band can revisit
   localparam int FILL_COLUMNS = 128;

   typedef struct packed {
      logic [DIST_W-1:0]    distance;
      logic [COL_CNT_W-1:0] column;
      logic [ROW_CNT_W-1:0] row;
      logic                 frame_end;
   } pixel_result_type;

   typedef struct {
      logic [CSR_DATA_W-1:0] width_raw;
      logic [CSR_DATA_W-1:0] bands_raw;
      logic [CSR_DATA_W-1:0] height_raw;
      int unsigned           beats;
      int unsigned           load_pct;
   } phase_type;

   // tracks the core state and the distances it still owes
   class distance_scoreboard_type;
      logic [SAMPLE_W-1:0]     ref_spectrum [MAX_BANDS];
      logic [SUM_W-1:0]        col_sums [MAX_WIDTH];
      logic [WIDTH_REG_W-1:0]  width_reg;
      logic [BANDS_REG_W-1:0]  bands_reg;
      logic [HEIGHT_REG_W-1:0] height_reg;
      int unsigned             col_pos;
      int unsigned             band_pos;
      int unsigned             row_pos;
      pixel_result_type        owed_pixels [$];
      int unsigned             errors;

      function new();
         width_reg  = WIDTH_RESET;
         bands_reg  = BANDS_RESET;
         height_reg = HEIGHT_RESET;
         col_pos    = 0;
         band_pos   = 0;
         row_pos    = 0;
         errors     = 0;
         foreach (ref_spectrum[i]) ref_spectrum[i] = '0;
         foreach (col_sums[i]) col_sums[i] = '0;
      endfunction

      function int unsigned pending();
         return owed_pixels.size();
      endfunction

      // zero reads as one, large values saturate
      function int unsigned lane_limit(int unsigned raw, int unsigned top);
         if (raw == 0) return 1;
         return (raw > top) ? top : raw;
      endfunction

      // greedy bit-by-bit floor square root
      function logic [DIST_W-1:0] floor_root(logic [SUM_W-1:0] v);
         logic [ROOT_W-1:0] root;
         logic [ROOT_W-1:0] trial;
         logic [63:0]       trial_sq;
         root = '0;
         for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial    = root | (ROOT_W'(1) << i);
            trial_sq = 64'(trial) * 64'(trial);
            if (trial_sq <= 64'(v)) root = trial;
         end
         return root[DIST_W-1:0];
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:  width_reg  = data[WIDTH_REG_W-1:0];
            CSR_BAND_COUNT:   bands_reg  = data[BANDS_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      endfunction

      // one accepted request beat
      function void accept_beat(logic func, logic [REF_BAND_W-1:0] band_sel,
                                logic [SAMPLE_IN_W-1:0] raw);
         logic [SAMPLE_W-1:0] level;
         logic [SAMPLE_W-1:0] refv;
         logic [SAMPLE_W-1:0] gap;
         logic [SUM_W-1:0]    gap_sq;
         logic [SUM_W-1:0]    acc;
         int unsigned         wlim, blim, hlim, col, band, row;
         bit                  last_band, last_col, last_row;
         pixel_result_type    px;
         level = raw[SAMPLE_IN_W-1] ? '0 : raw[SAMPLE_W-1:0];
         if (func == FUNC_LOAD) begin
            ref_spectrum[band_sel] = level;
            return;
         end
         wlim = lane_limit(width_reg, WLIM_MAX);
         blim = lane_limit(bands_reg, BLIM_MAX);
         hlim = lane_limit(height_reg, HLIM_MAX);
         // counters past a shrunken limit restart at zero
         col  = (col_pos >= wlim) ? 0 : col_pos;
         band = (band_pos >= blim) ? 0 : band_pos;
         row  = (row_pos >= hlim) ? 0 : row_pos;
         // squared difference accumulated per column
         refv   = ref_spectrum[band];
         gap    = (level >= refv) ? level - refv : refv - level;
         gap_sq = SUM_W'(gap) * SUM_W'(gap);
         acc    = (band == 0) ? '0 : col_sums[col];
         acc    = acc + gap_sq;
         col_sums[col] = acc;
         last_band = (band + 1 >= blim);
         last_col  = (col + 1 >= wlim);
         last_row  = (row + 1 >= hlim);
         if (last_band) begin
            px.distance  = floor_root(acc);
            px.column    = COL_CNT_W'(col);
            px.row       = ROW_CNT_W'(row);
            px.frame_end = last_col && last_row;
            owed_pixels.push_back(px);
         end
         // band-interleaved-by-line walk
         if (!last_col) begin
            col++;
         end else begin
            col = 0;
            if (!last_band) begin
               band++;
            end else begin
               band = 0;
               row  = last_row ? 0 : row + 1;
            end
         end
         col_pos  = col;
         band_pos = band;
         row_pos  = row;
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("mismatch: %s", what);
      endtask

      // one accepted response beat against the oldest owed pixel
      task check_pixel(pixel_result_type got);
         pixel_result_type want;
         if (owed_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result col %0d row %0d dist %0d",
                                      got.column, got.row, got.distance));
            return;
         end
         want = owed_pixels.pop_front();
         if (got.distance !== want.distance)
            report_mismatch($sformatf("distance got %0d want %0d at col %0d row %0d",
                                      got.distance, want.distance, want.column, want.row));
         if (got.column !== want.column)
            report_mismatch($sformatf("pixel_column got %0d want %0d",
                                      got.column, want.column));
         if (got.row !== want.row)
            report_mismatch($sformatf("pixel_row got %0d want %0d at col %0d",
                                      got.row, want.row, want.column));
         if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end got %0b want %0b at col %0d row %0d",
                                      got.frame_end, want.frame_end, want.column, want.row));
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_func = FUNC_SAMPLE;
   logic [REF_BAND_W-1:0]         req_ref_band = '0;
   logic signed [SAMPLE_IN_W-1:0] req_sample_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [DIST_W-1:0]             rsp_distance;
   logic [COL_CNT_W-1:0]          rsp_pixel_column;
   logic [ROW_CNT_W-1:0]          rsp_pixel_row;
   logic                          rsp_frame_end;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]         csr_data = '0;

   distance_scoreboard_type sb = new();
   int unsigned send_idle_pct = 23;
   int unsigned recv_idle_pct = 84;
   int unsigned beats_sent = 0;
   int unsigned total_beats = 1;

   spectral_euclidean_distance_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_ref_band     (req_ref_band),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance     (rsp_distance),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_frame_end    (rsp_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: check accepted beats, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pixel('{rsp_distance, rsp_pixel_column, rsp_pixel_row, rsp_frame_end});
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // run limit
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // mix of negatives, extremes, small and full-range values
   function automatic logic signed [SAMPLE_IN_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000 | 16'($urandom_range(0, 32767));
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   // one request beat, with a random gap ahead of it
   task automatic send_beat(logic func, logic [REF_BAND_W-1:0] band_sel,
                            logic signed [SAMPLE_IN_W-1:0] value);
      case (beats_sent * 3 / total_beats)
         0: begin
            send_idle_pct = 23;
            recv_idle_pct = 84;
         end
         1: begin
            send_idle_pct = 84;
            recv_idle_pct = 23;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_ref_band     <= band_sel;
      req_sample_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.accept_beat(func, band_sel, value);
      beats_sent++;
   endtask

   // register write, valid left high for a following write
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic write_limits(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] b,
                               logic [CSR_DATA_W-1:0] h);
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_BAND_COUNT, b);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   // wait for every owed pixel and for the core to go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      phase_type   plan [$];
      phase_type   p;
      int unsigned random_beats;
      random_beats = 0;

      // random small frames, some with odd register values
      while (random_beats < 350) begin
         p.width_raw  = CSR_DATA_W'($urandom_range(1, 9));
         p.bands_raw  = CSR_DATA_W'($urandom_range(1, 6));
         p.height_raw = CSR_DATA_W'($urandom_range(1, 4));
         case ($urandom_range(0, 9))
            0: p.width_raw = '0;
            1: p.bands_raw = p.bands_raw | 11'h600;
            2: p.height_raw = '0;
            3: p.height_raw = CSR_DATA_W'($urandom);
            4: begin
               p.width_raw = CSR_DATA_W'($urandom);
               p.bands_raw = CSR_DATA_W'(1);
            end
            default: ;
         endcase
         p.beats    = $urandom_range(30, 120);
         p.load_pct = 10;
         plan.push_back(p);
         random_beats += p.beats;
      end

      // register extremes, dropped in at random points
      p = '{11'd0, 11'h200, 11'd0, 40, 10};
      plan.insert($urandom_range(0, plan.size()), p);
      p = '{11'd2047, 11'd1, 11'd3, 40, 10};
      plan.insert($urandom_range(0, plan.size()), p);
      p = '{11'd1, 11'h1FF, 11'd2, 270, 5};
      plan.insert($urandom_range(0, plan.size()), p);
      p = '{11'd1, 11'd1, 11'd2047, 100, 5};
      plan.insert($urandom_range(0, plan.size()), p);
      p = '{11'd1024, 11'd256, 11'd1024, 100, 10};
      plan.insert($urandom_range(0, plan.size()), p);

      total_beats = MAX_BANDS + FILL_COLUMNS + 17;
      foreach (plan[i]) total_beats += plan[i].beats;

      // reset
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full reference spectrum, then one line over the low columns so
      // every sum that a later band revisits holds a value
      write_limits(CSR_DATA_W'(FILL_COLUMNS), 11'd1, 11'd1);
      for (int b = 0; b < MAX_BANDS; b++)
         send_beat(FUNC_LOAD, REF_BAND_W'(b), pick_sample());
      for (int c = 0; c < FILL_COLUMNS; c++)
         send_beat(FUNC_SAMPLE, REF_BAND_W'($urandom), pick_sample());
      settle();

      // directed: 2x2 frame of 3 bands, clamping and full-scale differences
      write_limits(11'd2, 11'd3, 11'd2);
      send_beat(FUNC_LOAD, 8'd0, -16'sd32768);
      send_beat(FUNC_LOAD, 8'd1, 16'sd32767);
      send_beat(FUNC_LOAD, 8'd2, 16'sd100);
      send_beat(FUNC_LOAD, 8'd255, -16'sd1);
      send_beat(FUNC_SAMPLE, 8'd0, 16'sd32767);
      send_beat(FUNC_SAMPLE, 8'd255, -16'sd1);
      send_beat(FUNC_SAMPLE, 8'd0, -16'sd32768);
      send_beat(FUNC_SAMPLE, 8'd0, 16'sd32767);
      // reference reload between bands of the same line
      send_beat(FUNC_LOAD, 8'd2, 16'sd32767);
      send_beat(FUNC_SAMPLE, 8'd0, 16'sd0);
      send_beat(FUNC_SAMPLE, 8'd0, 16'sd32767);
      send_beat(FUNC_SAMPLE, 8'd0, 16'sd0);
      send_beat(FUNC_SAMPLE, 8'd0, 16'sd16384);
      send_beat(FUNC_SAMPLE, 8'd0, 16'sd1);
      send_beat(FUNC_SAMPLE, 8'd0, -16'sd2);
      send_beat(FUNC_SAMPLE, 8'd0, 16'sd32767);
      send_beat(FUNC_SAMPLE, 8'd170, -16'sd32768);

      // random phases, limits changed between them mid-frame
      foreach (plan[i]) begin
         settle();
         write_limits(plan[i].width_raw, plan[i].bands_raw, plan[i].height_raw);
         for (int n = 0; n < plan[i].beats; n++) begin
            if ($urandom_range(0, 99) < plan[i].load_pct)
               send_beat(FUNC_LOAD,
                         $urandom_range(0, 1) ? REF_BAND_W'($urandom_range(0, 7))
                                              : REF_BAND_W'($urandom),
                         pick_sample());
            else
               send_beat(FUNC_SAMPLE, REF_BAND_W'($urandom), pick_sample());
         end
      end

      settle();
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/sedist_pkg.sv
rtl/core/sedist_isqrt.sv
rtl/core/spectral_euclidean_distance_core.sv
rtl/core/sedist_checker.sv
dv/spectral_euclidean_distance_core_tb.sv
